// ----- src/tlt_pkg.sv -----
package tlt_pkg;

    localparam int COORD_W             = 24;
    localparam int WIDTH_W             = 16;
    localparam int COLOR_W             = 32;
    localparam int NRM_BITS            = 15;
    localparam int WIDTH_FRAC_BITS     = 8;
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int VERTS               = 6 * 3;
    localparam int VIDX_W              = $clog2(VERTS);
    localparam int DIFF_W              = COORD_W + 1;
    localparam int RAD_W               = 2 * DIFF_W + 2;
    localparam int ROOT_W              = RAD_W / 2;
    localparam int REM_W               = ROOT_W + 1;
    localparam int NUM_W               = DIFF_W + NRM_BITS + 2;
    localparam int Q_W                 = NRM_BITS + 1;
    localparam int PROD_W              = Q_W + WIDTH_W;
    localparam int NW_W                = 26;
    localparam int SUM_W               = NW_W + 2;
    localparam int FIFO_DEPTH          = 2;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [2:0] CORNER_ORDER [VERTS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd4, 3'd2,
        3'd3, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6, 3'd7, 3'd5
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [WIDTH_W-1:0]        offset_width;
        logic [7:0]                color_red;
        logic [7:0]                color_green;
        logic [7:0]                color_blue;
        logic [7:0]                color_alpha;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [COLOR_W-1:0]        vertex_color;
        logic                      last_vertex;
    } t_out_item;

    typedef struct packed {
        t_in_item            item;
        logic [DIFF_W-1:0]   ax;
        logic [DIFF_W-1:0]   ay;
        logic                nx_neg;
        logic                ny_neg;
        logic                zero;
        logic [ROOT_W-1:0]   len;
    } t_job;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [NW_W-1:0]    nw_x;
        logic signed [NW_W-1:0]    nw_y;
        logic [COLOR_W-1:0]        color;
    } t_seg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    typedef struct packed {
        logic use_start;
        logic n_pos;
        logic t_neg;
        logic t_pos;
    } t_corner;

    function automatic t_corner corner_of(input logic [2:0] c);
        t_corner r;
        r.use_start = c[2];
        r.n_pos     = c[0];
        r.t_neg     = (c[2:1] == 2'b00);
        r.t_pos     = (c[2:1] == 2'b11);
        return r;
    endfunction

endpackage

// ----- src/tlt_front.sv -----
module tlt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tlt_pkg::t_in_item i_in_data,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output tlt_pkg::t_job   o_job
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_NORM = 5'b00010,
        F_SQ   = 5'b00100,
        F_ROOT = 5'b01000,
        F_HAND = 5'b10000
    } t_fstate;

    localparam int ROOT_STEPS = tlt_pkg::ROOT_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    t_fstate                        r_state;
    tlt_pkg::t_in_item              r_item;
    logic [tlt_pkg::DIFF_W-1:0]     r_ax, r_ay;
    logic                           r_nx_neg, r_ny_neg, r_zero;
    logic [tlt_pkg::RAD_W-1:0]      r_rad;
    logic [tlt_pkg::ROOT_W-1:0]     r_root;
    logic [tlt_pkg::REM_W-1:0]      r_rem;
    logic [CNT_W-1:0]               r_cnt;

    logic                           w_accept;
    logic signed [tlt_pkg::DIFF_W-1:0] w_dx, w_dy;
    logic [tlt_pkg::DIFF_W-1:0]     w_m;
    logic [4:0]                     w_lz;
    logic [tlt_pkg::ROOT_W-1:0]     n_root;
    logic [tlt_pkg::REM_W-1:0]      n_rem;

    assign o_in_ready = (r_state == F_IDLE) || ((r_state == F_HAND) && i_job_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_dx = tlt_pkg::DIFF_W'(i_in_data.end_x) - tlt_pkg::DIFF_W'(i_in_data.start_x);
    assign w_dy = tlt_pkg::DIFF_W'(i_in_data.end_y) - tlt_pkg::DIFF_W'(i_in_data.start_y);
    assign w_m  = (r_ax > r_ay) ? r_ax : r_ay;

    // leading zeros so the larger magnitude lands on the top bit
    always_comb begin
        w_lz = '0;
        for (int i = 0; i < tlt_pkg::DIFF_W; i++) begin
            if (w_m[i]) begin
                w_lz = 5'(tlt_pkg::DIFF_W - 1 - i);
            end
        end
    end

    // two digit steps of the square root per cycle
    always_comb begin
        logic [tlt_pkg::REM_W+1:0] t_rem;
        logic [tlt_pkg::REM_W+1:0] t_try;
        n_root = r_root;
        n_rem  = r_rem;
        for (int s = 0; s < 2; s++) begin
            t_rem = {n_rem, r_rad[tlt_pkg::RAD_W-1-2*s -: 2]};
            t_try = {1'b0, n_root, 2'b01};
            if (t_rem >= t_try) begin
                n_rem  = tlt_pkg::REM_W'(t_rem - t_try);
                n_root = {n_root[tlt_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = tlt_pkg::REM_W'(t_rem);
                n_root = {n_root[tlt_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE, F_HAND: begin
                    if (w_accept) begin
                        r_state <= F_NORM;
                    end else if (r_state == F_HAND && i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                F_NORM: begin
                    r_state <= r_zero ? F_HAND : F_SQ;
                end
                F_SQ: begin
                    r_state <= F_ROOT;
                end
                F_ROOT: begin
                    if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                        r_state <= F_HAND;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item   <= i_in_data;
            r_ax     <= w_dx[tlt_pkg::DIFF_W-1] ? tlt_pkg::DIFF_W'(-w_dx) : w_dx;
            r_ay     <= w_dy[tlt_pkg::DIFF_W-1] ? tlt_pkg::DIFF_W'(-w_dy) : w_dy;
            r_nx_neg <= (w_dy > 0);
            r_ny_neg <= w_dx[tlt_pkg::DIFF_W-1];
            r_zero   <= (w_dx == 0) && (w_dy == 0);
        end
        if (r_state == F_NORM) begin
            r_ax <= tlt_pkg::DIFF_W'(r_ax << w_lz);
            r_ay <= tlt_pkg::DIFF_W'(r_ay << w_lz);
        end
        if (r_state == F_SQ) begin
            r_rad  <= tlt_pkg::RAD_W'(r_ax * r_ax) + tlt_pkg::RAD_W'(r_ay * r_ay);
            r_root <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
        end
        if (r_state == F_ROOT) begin
            r_rad  <= {r_rad[tlt_pkg::RAD_W-5:0], 4'b0000};
            r_root <= n_root;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_job_valid  = (r_state == F_HAND);
    assign o_job.item   = r_item;
    assign o_job.ax     = r_ax;
    assign o_job.ay     = r_ay;
    assign o_job.nx_neg = r_nx_neg;
    assign o_job.ny_neg = r_ny_neg;
    assign o_job.zero   = r_zero;
    assign o_job.len    = r_root;

endmodule

// ----- src/tlt_div.sv -----
module tlt_div #(
    parameter int COORD_FRAC_BITS = tlt_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  tlt_pkg::t_job i_job,
    output logic          o_seg_valid,
    input  logic          i_seg_ready,
    output tlt_pkg::t_seg o_seg
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_DIV  = 4'b0010,
        D_MUL  = 4'b0100,
        D_RND  = 4'b1000
    } t_dstate;

    localparam int SH    = tlt_pkg::NRM_BITS + tlt_pkg::WIDTH_FRAC_BITS - COORD_FRAC_BITS;
    localparam int CNT_W = $clog2(tlt_pkg::Q_W);
    localparam logic [tlt_pkg::PROD_W:0] HALF = (tlt_pkg::PROD_W + 1)'(1) << (SH - 1);

    t_dstate                       r_state;
    tlt_pkg::t_in_item             r_item;
    logic                          r_nx_neg, r_ny_neg;
    logic [tlt_pkg::NUM_W-1:0]     r_remx, r_remy, r_den;
    logic [tlt_pkg::Q_W-1:0]       r_qx, r_qy;
    logic [tlt_pkg::PROD_W-1:0]    r_px, r_py;
    logic [CNT_W-1:0]              r_cnt;

    logic                          w_accept;
    logic [tlt_pkg::NUM_W-1:0]     w_half;
    logic [tlt_pkg::PROD_W:0]      w_rx, w_ry;
    logic [tlt_pkg::NW_W-2:0]      w_mx, w_my;

    assign o_job_ready = (r_state == D_IDLE) || ((r_state == D_RND) && i_seg_ready);
    assign w_accept    = i_job_valid && o_job_ready;
    assign w_half      = tlt_pkg::NUM_W'(i_job.len >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE, D_RND: begin
                    if (w_accept) begin
                        r_state <= i_job.zero ? D_MUL : D_DIV;
                    end else if (r_state == D_RND && i_seg_ready) begin
                        r_state <= D_IDLE;
                    end
                end
                D_DIV: begin
                    if (r_cnt == CNT_W'(tlt_pkg::Q_W - 1)) begin
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_state <= D_RND;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item   <= i_job.item;
            r_nx_neg <= i_job.nx_neg;
            r_ny_neg <= i_job.ny_neg;
            r_remx   <= (tlt_pkg::NUM_W'(i_job.ay) << tlt_pkg::NRM_BITS) + w_half;
            r_remy   <= (tlt_pkg::NUM_W'(i_job.ax) << tlt_pkg::NRM_BITS) + w_half;
            r_den    <= tlt_pkg::NUM_W'(i_job.len) << tlt_pkg::NRM_BITS;
            r_cnt    <= '0;
            // zero-length segment: normal is (1, 0)
            r_qx     <= i_job.zero ? tlt_pkg::Q_W'(1) << tlt_pkg::NRM_BITS : '0;
            r_qy     <= '0;
        end else if (r_state == D_DIV) begin
            if (r_remx >= r_den) begin
                r_remx <= r_remx - r_den;
                r_qx   <= {r_qx[tlt_pkg::Q_W-2:0], 1'b1};
            end else begin
                r_qx   <= {r_qx[tlt_pkg::Q_W-2:0], 1'b0};
            end
            if (r_remy >= r_den) begin
                r_remy <= r_remy - r_den;
                r_qy   <= {r_qy[tlt_pkg::Q_W-2:0], 1'b1};
            end else begin
                r_qy   <= {r_qy[tlt_pkg::Q_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == D_MUL) begin
            r_px <= r_qx * r_item.offset_width;
            r_py <= r_qy * r_item.offset_width;
        end
    end

    // round half away from zero on the magnitude
    assign w_rx = ((tlt_pkg::PROD_W + 1)'(r_px) + HALF) >> SH;
    assign w_ry = ((tlt_pkg::PROD_W + 1)'(r_py) + HALF) >> SH;
    assign w_mx = w_rx[tlt_pkg::NW_W-2:0];
    assign w_my = w_ry[tlt_pkg::NW_W-2:0];

    assign o_seg_valid   = (r_state == D_RND);
    assign o_seg.start_x = r_item.start_x;
    assign o_seg.start_y = r_item.start_y;
    assign o_seg.end_x   = r_item.end_x;
    assign o_seg.end_y   = r_item.end_y;
    assign o_seg.nw_x    = r_nx_neg ? -$signed({1'b0, w_mx}) : $signed({1'b0, w_mx});
    assign o_seg.nw_y    = r_ny_neg ? -$signed({1'b0, w_my}) : $signed({1'b0, w_my});
    assign o_seg.color   = {r_item.color_alpha, r_item.color_blue,
                            r_item.color_green, r_item.color_red};

endmodule

// ----- src/tlt_fifo.sv -----
module tlt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  tlt_pkg::t_seg     i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output tlt_pkg::t_seg     o_pop_data,
    output tlt_pkg::t_fifo_st o_status
);

    localparam int PTR_W = $clog2(tlt_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(tlt_pkg::FIFO_DEPTH + 1);

    tlt_pkg::t_seg    r_mem [tlt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_status.full  = (r_cnt == CNT_W'(tlt_pkg::FIFO_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_push_ready   = !o_status.full;
    assign o_pop_valid    = !o_status.empty;
    assign o_pop_data     = r_mem[r_rd];
    assign w_push         = i_push_valid && o_push_ready;
    assign w_pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(tlt_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(tlt_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ----- src/tlt_back.sv -----
module tlt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seg_valid,
    output logic               o_seg_ready,
    input  tlt_pkg::t_seg      i_seg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlt_pkg::t_out_item o_out_data
);

    localparam logic [tlt_pkg::VIDX_W-1:0] LAST_IDX = tlt_pkg::VIDX_W'(tlt_pkg::VERTS - 1);
    localparam logic signed [tlt_pkg::SUM_W-1:0] SAT_HI = tlt_pkg::SUM_W'(tlt_pkg::COORD_MAX);
    localparam logic signed [tlt_pkg::SUM_W-1:0] SAT_LO = tlt_pkg::SUM_W'(tlt_pkg::COORD_MIN);

    tlt_pkg::t_seg              r_seg;
    logic                       r_busy;
    logic [tlt_pkg::VIDX_W-1:0] r_k;
    logic                       r_out_valid;
    tlt_pkg::t_out_item         r_out;

    logic                       w_adv, w_emit, w_load;
    tlt_pkg::t_corner           w_c;
    logic signed [tlt_pkg::SUM_W-1:0] w_nx, w_ny, w_vx, w_vy;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign w_emit      = r_busy && w_adv;
    assign o_seg_ready = !r_busy || (w_emit && r_k == LAST_IDX);
    assign w_load      = i_seg_valid && o_seg_ready;

    assign w_c  = tlt_pkg::corner_of(tlt_pkg::CORNER_ORDER[r_k]);
    assign w_nx = tlt_pkg::SUM_W'(r_seg.nw_x);
    assign w_ny = tlt_pkg::SUM_W'(r_seg.nw_y);

    // tw = (-nw.y, nw.x)
    always_comb begin
        w_vx = w_c.use_start ? tlt_pkg::SUM_W'(r_seg.start_x) : tlt_pkg::SUM_W'(r_seg.end_x);
        w_vy = w_c.use_start ? tlt_pkg::SUM_W'(r_seg.start_y) : tlt_pkg::SUM_W'(r_seg.end_y);
        w_vx = w_c.n_pos ? w_vx + w_nx : w_vx - w_nx;
        w_vy = w_c.n_pos ? w_vy + w_ny : w_vy - w_ny;
        if (w_c.t_pos) begin
            w_vx = w_vx - w_ny;
            w_vy = w_vy + w_nx;
        end else if (w_c.t_neg) begin
            w_vx = w_vx + w_ny;
            w_vy = w_vy - w_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (w_emit) begin
                if (r_k == LAST_IDX) begin
                    r_busy <= 1'b0;
                end
                r_k <= r_k + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_seg <= i_seg;
        end
        if (w_emit) begin
            priority if (w_vx > SAT_HI) begin
                r_out.vertex_x <= tlt_pkg::COORD_MAX;
            end else if (w_vx < SAT_LO) begin
                r_out.vertex_x <= tlt_pkg::COORD_MIN;
            end else begin
                r_out.vertex_x <= w_vx[tlt_pkg::COORD_W-1:0];
            end
            priority if (w_vy > SAT_HI) begin
                r_out.vertex_y <= tlt_pkg::COORD_MAX;
            end else if (w_vy < SAT_LO) begin
                r_out.vertex_y <= tlt_pkg::COORD_MIN;
            end else begin
                r_out.vertex_y <= w_vy[tlt_pkg::COORD_W-1:0];
            end
            r_out.vertex_color <= r_seg.color;
            r_out.last_vertex  <= (r_k == LAST_IDX);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/thick_line_triangulator.sv -----
// path: an input beat passes the front end (normalize, square, square root), the divide
// unit, the queue and the vertex stage; a zero-length segment skips the square root and
// the divide. Each segment gives 18 vertex beats, back to back from the one-vertex-per-cycle
// output while i_out_ready holds; the divide unit takes 16 quotient steps and the square
// root front end makes 2 result bits a cycle
// reset: synchronous active low, clears all handshake and sequencing state
module thick_line_triangulator #(
    parameter int COORD_FRAC_BITS = tlt_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tlt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlt_pkg::t_out_item o_out_data
);

    logic              w_job_valid, w_job_ready;
    tlt_pkg::t_job     w_job;
    logic              w_push_valid, w_push_ready;
    tlt_pkg::t_seg     w_push_seg;
    logic              w_pop_valid, w_pop_ready;
    tlt_pkg::t_seg     w_pop_seg;
    tlt_pkg::t_fifo_st w_fst;

    tlt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    tlt_div #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .o_seg_valid (w_push_valid),
        .i_seg_ready (w_push_ready),
        .o_seg       (w_push_seg)
    );

    tlt_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_seg),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_seg),
        .o_status     (w_fst)
    );

    tlt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (w_pop_valid),
        .o_seg_ready (w_pop_ready),
        .i_seg       (w_pop_seg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_fifo_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fst.full && w_fst.empty))
        else $error("queue reports full and empty together");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && w_push_ready) |=> !w_fst.empty)
        else $error("queue empty right after a push");

    a_job_needs_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && !w_job_ready) |-> !w_job_valid)
        else $error("front took a segment while its job was stuck");
`endif

endmodule
